### rtl/worker_to_core_interleave_mapper_core_macros.svh
// Assertion macros for the mapper RTL.
`ifndef WORKER_TO_CORE_INTERLEAVE_MAPPER_CORE_MACROS_SVH
`define WORKER_TO_CORE_INTERLEAVE_MAPPER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WCIM_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("wcim check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define WCIM_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("wcim check failed");

`else

`define WCIM_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons)
`define WCIM_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons)

`endif

`endif

### rtl/wcim_pkg.sv
`default_nettype none

package wcim_pkg;

    // Field widths of the transaction ports
    localparam int CMD_W    = 2;
    localparam int WORKER_W = 16;
    localparam int DSEL_W   = 3;
    localparam int SSEL_W   = 6;
    localparam int CNTV_W   = 7;
    localparam int CPUV_W   = 12;
    localparam int DCNT_W   = 4;
    localparam int DOM_W    = 3;
    localparam int CPU_W    = 12;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_MAP         = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_COUNT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_ENTRY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic write_count;
        logic write_table;
        logic div_first;
        logic div_second;
        logic save_dom;
        logic read_table;
        logic emit;
        logic emit_found;
        logic emit_dom_zero;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic dc_zero;
        logic div_done;
        logic count_zero;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/wcim_ram.sv
`default_nettype none

module wcim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/wcim_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module wcim_div #(
    parameter int NW  = 16,
    parameter int DVW = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [NW-1:0]  dividend,
    input  wire logic [DVW-1:0] divisor,
    output logic                done,
    output logic      [NW-1:0]  quotient,
    output logic      [DVW-1:0] remainder
);

    localparam int CW = (NW > 1) ? $clog2(NW) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

    logic           run_reg;
    logic           done_reg;
    logic [CW-1:0]  step_reg;
    logic [DVW-1:0] rem_reg;
    logic [NW-1:0]  quo_reg;
    logic [DVW-1:0] dvs_reg;

    logic [DVW:0]   shifted;
    logic [DVW:0]   diff;
    logic           ge;
    logic [DVW-1:0] rem_next;
    logic [NW-1:0]  quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NW-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        diff     = shifted - {1'b0, dvs_reg};
        rem_next = ge ? diff[DVW-1:0] : shifted[DVW-1:0];
        quo_next = {quo_reg[NW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### rtl/wcim_ctrl.sv
`default_nettype none

module wcim_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [wcim_pkg::CMD_W-1:0]    command,
    input  wire wcim_pkg::dp_stat_t            stat,
    output wcim_pkg::dp_cmd_t                  cmd,
    output logic                               busy
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DIV_DOM = 5'b00010,
        ST_CNT     = 5'b00100,
        ST_DIV_POS = 5'b01000,
        ST_TBL     = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (command)
                        wcim_pkg::CMD_MAP:
                        begin
                            if (stat.dc_zero)
                            begin
                                cmd.emit          = 1'b1;
                                cmd.emit_dom_zero = 1'b1;
                            end
                            else
                            begin
                                cmd.div_first = 1'b1;
                                state_next    = ST_DIV_DOM;
                            end
                        end
                        wcim_pkg::CMD_SET_COUNT:   cmd.write_count = 1'b1;
                        wcim_pkg::CMD_WRITE_ENTRY: cmd.write_table = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_DIV_DOM:
            begin
                if (stat.div_done)
                begin
                    cmd.save_dom = 1'b1;
                    state_next   = ST_CNT;
                end
            end
            ST_CNT:
            begin
                if (stat.count_zero)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.div_second = 1'b1;
                    state_next     = ST_DIV_POS;
                end
            end
            ST_DIV_POS:
            begin
                if (stat.div_done)
                begin
                    cmd.read_table = 1'b1;
                    state_next     = ST_TBL;
                end
            end
            ST_TBL:
            begin
                cmd.emit       = 1'b1;
                cmd.emit_found = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

### rtl/wcim_dp.sv
`default_nettype none

module wcim_dp #(
    parameter int MAX_DOMAINS          = 8,
    parameter int MAX_CORES_PER_DOMAIN = 64,
    parameter int CORE_ID_BITS         = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire wcim_pkg::dp_cmd_t               cmd,
    output wcim_pkg::dp_stat_t                   stat,
    input  wire logic                            cfg_write,
    input  wire logic [wcim_pkg::DCNT_W-1:0]     cfg_data,
    input  wire logic [wcim_pkg::WORKER_W-1:0]   worker_index,
    input  wire logic [wcim_pkg::DSEL_W-1:0]     domain_select,
    input  wire logic [wcim_pkg::SSEL_W-1:0]     slot_select,
    input  wire logic [wcim_pkg::CNTV_W-1:0]     count_value,
    input  wire logic [wcim_pkg::CPUV_W-1:0]     cpu_value,
    output logic                                 done,
    output logic      [wcim_pkg::DOM_W-1:0]      domain_slot,
    output logic      [wcim_pkg::CPU_W-1:0]      cpu_number,
    output logic                                 cpu_valid
);

    localparam int DCW       = wcim_pkg::DCNT_W;
    localparam int WW        = wcim_pkg::WORKER_W;
    localparam int DOMW      = wcim_pkg::DOM_W;
    localparam int CPUW      = wcim_pkg::CPU_W;
    localparam int DAW       = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
    localparam int TBL_DEPTH = MAX_DOMAINS * MAX_CORES_PER_DOMAIN;
    localparam int TAW       = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int CNT_W     = $clog2(MAX_CORES_PER_DOMAIN + 1);
    localparam int DVW       = (CNT_W > DCW) ? CNT_W : DCW;
    localparam int EXT_W     = (CORE_ID_BITS > CPUW) ? CORE_ID_BITS : CPUW;

    logic [DCW-1:0]          dcount_reg;
    logic [31:0]             dc_full;
    logic [DCW-1:0]          dc_act;

    logic                    div_start;
    logic [WW-1:0]           div_dividend;
    logic [DVW-1:0]          div_divisor;
    logic                    div_done;
    logic [WW-1:0]           div_quo;
    logic [DVW-1:0]          div_rem;

    logic [DCW-1:0]          dom_reg;
    logic [WW-1:0]           quo_reg;

    logic                    dsel_ok;
    logic                    ssel_ok;
    logic [31:0]             cnt_full;
    logic [CNT_W-1:0]        cnt_wdata;
    logic [DAW-1:0]          cnt_raddr;
    logic [CNT_W-1:0]        cnt_rdata;
    logic [MAX_DOMAINS-1:0]  cnt_vld_reg;
    logic                    cnt_vld_rd_reg;
    logic [CNT_W-1:0]        cnt_eff;

    logic [31:0]             tbl_waddr_full;
    logic [31:0]             tbl_raddr_full;
    logic [EXT_W-1:0]        cpu_ext;
    logic [CORE_ID_BITS-1:0] tbl_rdata;
    logic [EXT_W-1:0]        tbl_ext;

    logic                    done_reg;
    logic [DOMW-1:0]         dom_out_reg;
    logic [CPUW-1:0]         cpu_out_reg;
    logic                    vld_out_reg;

    // Clamp the domain count to the table size
    always_comb
    begin
        dc_full = (32'(dcount_reg) > 32'(MAX_DOMAINS)) ? 32'(MAX_DOMAINS) : 32'(dcount_reg);
        dc_act  = dc_full[DCW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcount_reg <= '0;
        end
        else if (cfg_write)
        begin
            dcount_reg <= cfg_data;
        end
    end

    // Shared divider: worker / domain count, then quotient / core count
    assign div_start    = cmd.div_first | cmd.div_second;
    assign div_dividend = cmd.div_first ? worker_index : quo_reg;
    assign div_divisor  = cmd.div_first ? DVW'(dc_act) : DVW'(cnt_eff);

    wcim_div #(
        .NW  (WW),
        .DVW (DVW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.save_dom)
        begin
            dom_reg <= DCW'(div_rem);
            quo_reg <= div_quo;
        end
    end

    // Per-domain core counts; an unwritten entry reads as zero
    always_comb
    begin
        dsel_ok   = 32'(domain_select) < 32'(MAX_DOMAINS);
        ssel_ok   = 32'(slot_select) < 32'(MAX_CORES_PER_DOMAIN);
        cnt_full  = (32'(count_value) > 32'(MAX_CORES_PER_DOMAIN)) ?
                    32'(MAX_CORES_PER_DOMAIN) : 32'(count_value);
        cnt_wdata = cnt_full[CNT_W-1:0];
        cnt_raddr = DAW'(div_rem);
        cnt_eff   = cnt_vld_rd_reg ? cnt_rdata : '0;
    end

    wcim_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_DOMAINS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cmd.write_count & dsel_ok),
        .waddr (DAW'(domain_select)),
        .wdata (cnt_wdata),
        .re    (cmd.save_dom),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg    <= '0;
            cnt_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_count && dsel_ok)
            begin
                cnt_vld_reg[DAW'(domain_select)] <= 1'b1;
            end
            if (cmd.save_dom)
            begin
                cnt_vld_rd_reg <= cnt_vld_reg[cnt_raddr];
            end
        end
    end

    // Core table, one row of slots per domain
    always_comb
    begin
        tbl_waddr_full = 32'(domain_select) * 32'(MAX_CORES_PER_DOMAIN) + 32'(slot_select);
        tbl_raddr_full = 32'(dom_reg) * 32'(MAX_CORES_PER_DOMAIN) + 32'(div_rem);
        cpu_ext        = EXT_W'(cpu_value);
        tbl_ext        = EXT_W'(tbl_rdata);
    end

    wcim_ram #(
        .WIDTH (CORE_ID_BITS),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (cmd.write_table & dsel_ok & ssel_ok),
        .waddr (tbl_waddr_full[TAW-1:0]),
        .wdata (cpu_ext[CORE_ID_BITS-1:0]),
        .re    (cmd.read_table),
        .raddr (tbl_raddr_full[TAW-1:0]),
        .rdata (tbl_rdata)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            dom_out_reg <= cmd.emit_dom_zero ? '0 : DOMW'(dom_reg);
            cpu_out_reg <= cmd.emit_found ? tbl_ext[CPUW-1:0] : '0;
            vld_out_reg <= cmd.emit_found;
        end
    end

    assign stat.dc_zero    = (dc_act == '0);
    assign stat.div_done   = div_done;
    assign stat.count_zero = (cnt_eff == '0);

    assign done        = done_reg;
    assign domain_slot = dom_out_reg;
    assign cpu_number  = cpu_out_reg;
    assign cpu_valid   = vld_out_reg;

endmodule

`default_nettype wire

### rtl/worker_to_core_interleave_mapper_core.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------------
// config    | cfg_write          | cfg_data (domain count)
// command   | start & !busy      | command, worker_index, domain_select,
//           |                    | slot_select, count_value, cpu_value
// result    | done (one cycle)   | domain_slot, cpu_number, cpu_valid
//
// A map transaction keeps busy high from acceptance through two 16-step
// restoring divisions on one shared divider (worker by domain count, then
// quotient by core count) plus a count memory read and a table read.
// An empty domain drops busy after the first division and the count check;
// with no topology busy never rises and the result follows in the cycle
// after acceptance. Count and table writes never raise busy.
// The result appears for one cycle on done, in the cycle busy drops; a new
// transaction may be accepted in that same cycle. The receiver cannot stall.
// Reset is asynchronous and active low; it clears the domain count and all
// per-domain core counts. Table entries hold nothing until written.
`default_nettype none
`include "worker_to_core_interleave_mapper_core_macros.svh"

module worker_to_core_interleave_mapper_core #(
    parameter int MAX_DOMAINS          = 8,
    parameter int MAX_CORES_PER_DOMAIN = 64,
    parameter int CORE_ID_BITS         = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_write,
    input  wire logic [wcim_pkg::DCNT_W-1:0]     cfg_data,
    // command transaction
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [wcim_pkg::CMD_W-1:0]      command,
    input  wire logic [wcim_pkg::WORKER_W-1:0]   worker_index,
    input  wire logic [wcim_pkg::DSEL_W-1:0]     domain_select,
    input  wire logic [wcim_pkg::SSEL_W-1:0]     slot_select,
    input  wire logic [wcim_pkg::CNTV_W-1:0]     count_value,
    input  wire logic [wcim_pkg::CPUV_W-1:0]     cpu_value,
    // result transaction
    output logic                                 done,
    output logic      [wcim_pkg::DOM_W-1:0]      domain_slot,
    output logic      [wcim_pkg::CPU_W-1:0]      cpu_number,
    output logic                                 cpu_valid
);

    wcim_pkg::dp_cmd_t  dp_cmd;
    wcim_pkg::dp_stat_t dp_stat;

    // Sequencer: decode the transaction, step through up to two divisions
    // and two memory reads, then fire the result.
    wcim_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (dp_stat),
        .cmd     (dp_cmd),
        .busy    (busy)
    );

    // Datapath: config register, divider, count and table memories,
    // result register.
    wcim_dp #(
        .MAX_DOMAINS          (MAX_DOMAINS),
        .MAX_CORES_PER_DOMAIN (MAX_CORES_PER_DOMAIN),
        .CORE_ID_BITS         (CORE_ID_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .worker_index  (worker_index),
        .domain_select (domain_select),
        .slot_select   (slot_select),
        .count_value   (count_value),
        .cpu_value     (cpu_value),
        .done          (done),
        .domain_slot   (domain_slot),
        .cpu_number    (cpu_number),
        .cpu_valid     (cpu_valid)
    );

    // A result only leaves while the sequencer is idle.
    `WCIM_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)

    // A result only follows a busy cycle or an accepted map command.
    `WCIM_ASSERT_IMP(a_done_cause, clk, rst_n, done, $past(busy || (start && command == wcim_pkg::CMD_MAP)))

    // Leaving the busy state always delivers the result in that cycle.
    `WCIM_ASSERT_IMP(a_idle_with_result, clk, rst_n, $fell(busy), done)

endmodule

`default_nettype wire
